// ----- hw/rtl/cds_pkg.sv -----
// Package for the calendar date stepper: field widths, action codes,
// micro-operation and branch-condition codes, and the control/status structs.
// Depends on nothing; used by every module of the block.
package cds_pkg;

    localparam int unsigned ACT_W   = 3;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned AMT_W   = 16;
    localparam int unsigned WD_W    = 3;
    localparam int unsigned STEP_W  = 6;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    localparam logic [ACT_W-1:0] ACT_ADD_DAYS    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_MONTHS  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD_YEARS   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NEXT_SUNDAY = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NEXT_WEEKDAY = 3'd4;

    typedef logic [STEP_W-1:0] cds_step_t;

    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_CENT_Y  = 4'd1,
        OP_LEAP    = 4'd2,
        OP_CHECK   = 4'd3,
        OP_CENT_W  = 4'd4,
        OP_WSUM    = 4'd5,
        OP_WMOD    = 4'd6,
        OP_NEXTDAY = 4'd7,
        OP_MQ      = 4'd8,
        OP_MADD    = 4'd9,
        OP_YADD    = 4'd10,
        OP_CLAMP   = 4'd11,
        OP_SAT     = 4'd12,
        OP_DONE    = 4'd13
    } cds_op_t;

    typedef enum logic [3:0] {
        CND_NONE        = 4'd0,
        CND_ALWAYS      = 4'd1,
        CND_INVALID     = 4'd2,
        CND_ACT_DAYS    = 4'd3,
        CND_ACT_MONTHS  = 4'd4,
        CND_ACT_YEARS   = 4'd5,
        CND_ACT_SUNDAY  = 4'd6,
        CND_ACT_WEEKDAY = 4'd7,
        CND_CNT_ZERO    = 4'd8,
        CND_YEAR_END    = 4'd9,
        CND_OVF         = 4'd10,
        CND_SEEK        = 4'd11
    } cds_cond_t;

    typedef struct packed {
        cds_op_t   op;
        cds_cond_t cond;
        cds_step_t target;
    } cds_uword_t;

    typedef struct packed {
        logic    load;
        cds_op_t op;
    } cds_ctrl_t;

    typedef struct packed {
        logic             invalid;
        logic             cnt_zero;
        logic             year_end;
        logic             ovf;
        logic             seek_more;
        logic             out_free;
        logic [ACT_W-1:0] act;
    } cds_stat_t;

endpackage

// ----- hw/rtl/cds_sequencer.sv -----
// Micro-sequencer of the calendar date stepper: program ROM, step counter,
// branch selection and the input handshake. Depends on cds_pkg.
module cds_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cds_pkg::cds_stat_t  stat,
    output cds_pkg::cds_ctrl_t  ctrl
);

    // Program labels.
    localparam cds_pkg::cds_step_t L_A0      = 6'd12;
    localparam cds_pkg::cds_step_t L_A0_YEAR = 6'd15;
    localparam cds_pkg::cds_step_t L_A1      = 6'd18;
    localparam cds_pkg::cds_step_t L_YR_CHK  = 6'd20;
    localparam cds_pkg::cds_step_t L_A2      = 6'd24;
    localparam cds_pkg::cds_step_t L_SEEK    = 6'd25;
    localparam cds_pkg::cds_step_t L_SK_YEAR = 6'd28;
    localparam cds_pkg::cds_step_t L_FIN     = 6'd32;
    localparam cds_pkg::cds_step_t L_DONE    = 6'd36;
    localparam cds_pkg::cds_step_t L_NONE    = 6'd0;

    function automatic cds_pkg::cds_uword_t rom(input cds_pkg::cds_step_t step);
        cds_pkg::cds_uword_t w;
        case (step)
            // validate the input date and find its day of the week
            6'd0:  w = '{cds_pkg::OP_CENT_Y,  cds_pkg::CND_NONE,        L_NONE};
            6'd1:  w = '{cds_pkg::OP_LEAP,    cds_pkg::CND_NONE,        L_NONE};
            6'd2:  w = '{cds_pkg::OP_CHECK,   cds_pkg::CND_INVALID,     L_DONE};
            6'd3:  w = '{cds_pkg::OP_CENT_W,  cds_pkg::CND_NONE,        L_NONE};
            6'd4:  w = '{cds_pkg::OP_WSUM,    cds_pkg::CND_NONE,        L_NONE};
            6'd5:  w = '{cds_pkg::OP_WMOD,    cds_pkg::CND_NONE,        L_NONE};
            // dispatch on the action
            6'd6:  w = '{cds_pkg::OP_NOP,     cds_pkg::CND_ACT_DAYS,    L_A0};
            6'd7:  w = '{cds_pkg::OP_NOP,     cds_pkg::CND_ACT_MONTHS,  L_A1};
            6'd8:  w = '{cds_pkg::OP_NOP,     cds_pkg::CND_ACT_YEARS,   L_A2};
            6'd9:  w = '{cds_pkg::OP_NOP,     cds_pkg::CND_ACT_SUNDAY,  L_SEEK};
            6'd10: w = '{cds_pkg::OP_NOP,     cds_pkg::CND_ACT_WEEKDAY, L_SEEK};
            6'd11: w = '{cds_pkg::OP_NOP,     cds_pkg::CND_ALWAYS,      L_FIN};
            // add days
            6'd12: w = '{cds_pkg::OP_NOP,     cds_pkg::CND_CNT_ZERO,    L_FIN};
            6'd13: w = '{cds_pkg::OP_NEXTDAY, cds_pkg::CND_YEAR_END,    L_A0_YEAR};
            6'd14: w = '{cds_pkg::OP_NOP,     cds_pkg::CND_ALWAYS,      L_A0};
            6'd15: w = '{cds_pkg::OP_NOP,     cds_pkg::CND_OVF,         L_FIN};
            6'd16: w = '{cds_pkg::OP_CENT_Y,  cds_pkg::CND_NONE,        L_NONE};
            6'd17: w = '{cds_pkg::OP_LEAP,    cds_pkg::CND_ALWAYS,      L_A0};
            // add months, then the shared year check and day clamp
            6'd18: w = '{cds_pkg::OP_MQ,      cds_pkg::CND_NONE,        L_NONE};
            6'd19: w = '{cds_pkg::OP_MADD,    cds_pkg::CND_NONE,        L_NONE};
            6'd20: w = '{cds_pkg::OP_NOP,     cds_pkg::CND_OVF,         L_FIN};
            6'd21: w = '{cds_pkg::OP_CENT_Y,  cds_pkg::CND_NONE,        L_NONE};
            6'd22: w = '{cds_pkg::OP_LEAP,    cds_pkg::CND_NONE,        L_NONE};
            6'd23: w = '{cds_pkg::OP_CLAMP,   cds_pkg::CND_ALWAYS,      L_FIN};
            // add years
            6'd24: w = '{cds_pkg::OP_YADD,    cds_pkg::CND_ALWAYS,      L_YR_CHK};
            // next Sunday or next weekday
            6'd25: w = '{cds_pkg::OP_NEXTDAY, cds_pkg::CND_YEAR_END,    L_SK_YEAR};
            6'd26: w = '{cds_pkg::OP_NOP,     cds_pkg::CND_SEEK,        L_SEEK};
            6'd27: w = '{cds_pkg::OP_NOP,     cds_pkg::CND_ALWAYS,      L_FIN};
            6'd28: w = '{cds_pkg::OP_NOP,     cds_pkg::CND_OVF,         L_FIN};
            6'd29: w = '{cds_pkg::OP_CENT_Y,  cds_pkg::CND_NONE,        L_NONE};
            6'd30: w = '{cds_pkg::OP_LEAP,    cds_pkg::CND_SEEK,        L_SEEK};
            6'd31: w = '{cds_pkg::OP_NOP,     cds_pkg::CND_ALWAYS,      L_FIN};
            // saturate, weekday of the result, deliver
            6'd32: w = '{cds_pkg::OP_SAT,     cds_pkg::CND_NONE,        L_NONE};
            6'd33: w = '{cds_pkg::OP_CENT_W,  cds_pkg::CND_NONE,        L_NONE};
            6'd34: w = '{cds_pkg::OP_WSUM,    cds_pkg::CND_NONE,        L_NONE};
            6'd35: w = '{cds_pkg::OP_WMOD,    cds_pkg::CND_NONE,        L_NONE};
            6'd36: w = '{cds_pkg::OP_DONE,    cds_pkg::CND_NONE,        L_NONE};
            default: w = '{cds_pkg::OP_NOP,   cds_pkg::CND_ALWAYS,      L_FIN};
        endcase
        return w;
    endfunction

    logic                busy_reg, busy_next;
    cds_pkg::cds_step_t  upc_reg, upc_next;
    cds_pkg::cds_uword_t uw;
    logic                take;

    assign uw = rom(upc_reg);

    always_comb begin
        case (uw.cond)
            cds_pkg::CND_NONE:        take = 1'b0;
            cds_pkg::CND_ALWAYS:      take = 1'b1;
            cds_pkg::CND_INVALID:     take = stat.invalid;
            cds_pkg::CND_ACT_DAYS:    take = (stat.act == cds_pkg::ACT_ADD_DAYS);
            cds_pkg::CND_ACT_MONTHS:  take = (stat.act == cds_pkg::ACT_ADD_MONTHS);
            cds_pkg::CND_ACT_YEARS:   take = (stat.act == cds_pkg::ACT_ADD_YEARS);
            cds_pkg::CND_ACT_SUNDAY:  take = (stat.act == cds_pkg::ACT_NEXT_SUNDAY);
            cds_pkg::CND_ACT_WEEKDAY: take = (stat.act == cds_pkg::ACT_NEXT_WEEKDAY);
            cds_pkg::CND_CNT_ZERO:    take = stat.cnt_zero;
            cds_pkg::CND_YEAR_END:    take = stat.year_end;
            cds_pkg::CND_OVF:         take = stat.ovf;
            cds_pkg::CND_SEEK:        take = stat.seek_more;
            default:                  take = 1'b0;
        endcase
    end

    assign s_ready   = !busy_reg;
    assign ctrl.load = s_valid && !busy_reg;
    assign ctrl.op   = busy_reg ? uw.op : cds_pkg::OP_NOP;

    always_comb begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (!busy_reg) begin
            if (s_valid) begin
                busy_next = 1'b1;
                upc_next  = '0;
            end
        end else if (uw.op == cds_pkg::OP_DONE) begin
            // The last step waits here until the output register is free.
            if (stat.out_free) begin
                busy_next = 1'b0;
            end
        end else if (take) begin
            upc_next = uw.target;
        end else begin
            upc_next = cds_pkg::cds_step_t'(upc_reg + 6'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            upc_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (busy_reg && upc_reg == '0))
        else $error("accepted beat did not start the program at step zero");

    a_done_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && uw.op == cds_pkg::OP_DONE && stat.out_free) |=> !busy_reg)
        else $error("sequencer stayed busy after delivering a result");

    a_upc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (upc_reg <= L_DONE))
        else $error("step counter left the program");

endmodule

// ----- hw/rtl/cds_datapath.sv -----
// Datapath of the calendar date stepper: date, count and scratch registers,
// the micro-operations the sequencer selects, and the output register.
// Depends on cds_pkg.
module cds_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cds_pkg::cds_ctrl_t          ctrl,
    output cds_pkg::cds_stat_t          stat,
    input  logic [cds_pkg::ACT_W-1:0]   s_action,
    input  logic [cds_pkg::YEAR_W-1:0]  s_year,
    input  logic [cds_pkg::MONTH_W-1:0] s_month,
    input  logic [cds_pkg::DAY_W-1:0]   s_day,
    input  logic [cds_pkg::AMT_W-1:0]   s_amount,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cds_pkg::YEAR_W-1:0]  m_out_year,
    output logic [cds_pkg::MONTH_W-1:0] m_out_month,
    output logic [cds_pkg::DAY_W-1:0]   m_out_day,
    output logic [cds_pkg::WD_W-1:0]    m_weekday,
    output logic                        m_error
);

    localparam logic [cds_pkg::WD_W-1:0] WD_SUNDAY   = 3'd0;
    localparam logic [cds_pkg::WD_W-1:0] WD_SATURDAY = 3'd6;

    // Days in month m; out-of-range months only occur on invalid input.
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd2:                     n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                  n = 5'd31;
        endcase
        return n;
    endfunction

    // floor(31 * m / 12) for the shifted month 1..12.
    function automatic logic [4:0] month_term(input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd1:    n = 5'd2;
            4'd2:    n = 5'd5;
            4'd3:    n = 5'd7;
            4'd4:    n = 5'd10;
            4'd5:    n = 5'd12;
            4'd6:    n = 5'd15;
            4'd7:    n = 5'd18;
            4'd8:    n = 5'd20;
            4'd9:    n = 5'd23;
            4'd10:   n = 5'd25;
            4'd11:   n = 5'd28;
            4'd12:   n = 5'd31;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    // Remainder by seven, folding octal digits since eight is one modulo seven.
    function automatic logic [2:0] mod7(input logic [13:0] s);
        logic [4:0] a;
        logic [3:0] b;
        logic [2:0] c;
        a = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[8:6]) + 5'(s[11:9]) + 5'(s[13:12]);
        b = 4'(a[2:0]) + 4'(a[4:3]);
        c = 3'(b[2:0] + 3'(b[3]));
        return (c == 3'd7) ? 3'd0 : c;
    endfunction

    logic [2:0]  act_reg, act_next;
    logic [13:0] y_reg, y_next;
    logic [3:0]  m_reg, m_next;
    logic [4:0]  d_reg, d_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  c_reg, c_next;
    logic        leap_reg, leap_next;
    logic [13:0] s_reg, s_next;
    logic [2:0]  wd_reg, wd_next;
    logic [12:0] q_reg, q_next;
    logic        err_reg, err_next;
    logic        ovf_reg, ovf_next;
    logic        mv_reg, mv_next;
    logic [13:0] oy_reg, oy_next;
    logic [3:0]  om_reg, om_next;
    logic [4:0]  od_reg, od_next;
    logic [2:0]  owd_reg, owd_next;
    logic        oerr_reg, oerr_next;

    logic [4:0]  md;
    logic [13:0] y_prev;
    logic [13:0] cent_in;
    logic [26:0] cent_prod;
    logic [14:0] c100;
    logic        leap_calc;
    logic        invalid;
    logic [3:0]  m_shift;
    logic [14:0] wsum;
    logic [16:0] t_sum;
    logic [34:0] q_prod;
    logic [16:0] r_sum;
    logic [16:0] ysum;
    logic        out_free;

    assign md        = month_days(m_reg, leap_reg);
    assign y_prev    = (m_reg < 4'd3) ? 14'(y_reg - 14'd1) : y_reg;
    assign cent_in   = (ctrl.op == cds_pkg::OP_CENT_W) ? y_prev : y_reg;
    // floor(y / 100) by reciprocal, exact for every 14-bit year
    assign cent_prod = 27'(cent_in) * 27'd5243;
    assign c100      = (15'(c_reg) << 6) + (15'(c_reg) << 5) + (15'(c_reg) << 2);
    assign leap_calc = (y_reg[1:0] == 2'd0) &&
                       ((15'(y_reg) != c100) || (c_reg[1:0] == 2'd0));
    assign invalid   = (y_reg == 14'd0) || (y_reg > cds_pkg::YEAR_MAX) ||
                       (m_reg == 4'd0) || (m_reg > 4'd12) ||
                       (d_reg == 5'd0) || (d_reg > md);
    assign m_shift   = (m_reg < 4'd3) ? 4'(m_reg + 4'd10) : 4'(m_reg - 4'd2);
    assign wsum      = 15'(d_reg) + 15'(month_term(m_shift)) + 15'(y_prev) +
                       15'(y_prev >> 2) - 15'(c_reg) + 15'(c_reg >> 2);
    assign t_sum     = 17'(m_reg) - 17'd1 + 17'(cnt_reg);
    // floor(t / 12) by reciprocal, exact below 2^17
    assign q_prod    = 35'(t_sum) * 35'd174763;
    assign r_sum     = t_sum - ((17'(q_reg) << 3) + (17'(q_reg) << 2));
    assign ysum      = 17'(y_reg) +
                       ((ctrl.op == cds_pkg::OP_MADD) ? 17'(q_reg) : 17'(cnt_reg));
    assign out_free  = !mv_reg || m_ready;

    assign stat.invalid   = invalid;
    assign stat.cnt_zero  = (cnt_reg == 16'd0);
    assign stat.year_end  = (d_reg >= md) && (m_reg >= 4'd12);
    assign stat.ovf       = ovf_reg;
    assign stat.seek_more = (act_reg == cds_pkg::ACT_NEXT_SUNDAY) ?
                            (wd_reg != WD_SUNDAY) :
                            (wd_reg inside {WD_SUNDAY, WD_SATURDAY});
    assign stat.out_free  = out_free;
    assign stat.act       = act_reg;

    always_comb begin
        act_next  = act_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        c_next    = c_reg;
        leap_next = leap_reg;
        s_next    = s_reg;
        wd_next   = wd_reg;
        q_next    = q_reg;
        err_next  = err_reg;
        ovf_next  = ovf_reg;
        mv_next   = mv_reg && !m_ready;
        oy_next   = oy_reg;
        om_next   = om_reg;
        od_next   = od_reg;
        owd_next  = owd_reg;
        oerr_next = oerr_reg;
        if (ctrl.load) begin
            act_next = s_action;
            y_next   = s_year;
            m_next   = s_month;
            d_next   = s_day;
            cnt_next = s_amount;
            err_next = 1'b0;
            ovf_next = 1'b0;
        end else begin
            case (ctrl.op)
                cds_pkg::OP_CENT_Y, cds_pkg::OP_CENT_W: begin
                    c_next = cent_prod[26:19];
                end
                cds_pkg::OP_LEAP: begin
                    leap_next = leap_calc;
                end
                cds_pkg::OP_CHECK: begin
                    err_next = invalid;
                end
                cds_pkg::OP_WSUM: begin
                    s_next = wsum[13:0];
                end
                cds_pkg::OP_WMOD: begin
                    wd_next = mod7(s_reg);
                end
                cds_pkg::OP_NEXTDAY: begin
                    cnt_next = 16'(cnt_reg - 16'd1);
                    wd_next  = (wd_reg == WD_SATURDAY) ? WD_SUNDAY : 3'(wd_reg + 3'd1);
                    if (d_reg < md) begin
                        d_next = 5'(d_reg + 5'd1);
                    end else begin
                        d_next = 5'd1;
                        if (m_reg < 4'd12) begin
                            m_next = 4'(m_reg + 4'd1);
                        end else begin
                            m_next = 4'd1;
                            if (y_reg >= cds_pkg::YEAR_MAX) begin
                                ovf_next = 1'b1;
                            end else begin
                                y_next = 14'(y_reg + 14'd1);
                            end
                        end
                    end
                end
                cds_pkg::OP_MQ: begin
                    q_next = q_prod[33:21];
                end
                cds_pkg::OP_MADD, cds_pkg::OP_YADD: begin
                    if (ctrl.op == cds_pkg::OP_MADD) begin
                        m_next = 4'(r_sum[3:0] + 4'd1);
                    end
                    if (ysum > 17'(cds_pkg::YEAR_MAX)) begin
                        ovf_next = 1'b1;
                    end else begin
                        y_next = ysum[13:0];
                    end
                end
                cds_pkg::OP_CLAMP: begin
                    if (d_reg > md) begin
                        d_next = md;
                    end
                end
                cds_pkg::OP_SAT: begin
                    if (ovf_reg) begin
                        y_next = cds_pkg::YEAR_MAX;
                        m_next = 4'd12;
                        d_next = 5'd31;
                    end
                end
                cds_pkg::OP_DONE: begin
                    if (out_free) begin
                        mv_next   = 1'b1;
                        oy_next   = err_reg ? 14'd0 : y_reg;
                        om_next   = err_reg ? 4'd0 : m_reg;
                        od_next   = err_reg ? 5'd0 : d_reg;
                        owd_next  = err_reg ? 3'd0 : wd_reg;
                        oerr_next = err_reg || ovf_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg  <= 1'b0;
            err_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end else begin
            mv_reg  <= mv_next;
            err_reg <= err_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg  <= act_next;
        y_reg    <= y_next;
        m_reg    <= m_next;
        d_reg    <= d_next;
        cnt_reg  <= cnt_next;
        c_reg    <= c_next;
        leap_reg <= leap_next;
        s_reg    <= s_next;
        wd_reg   <= wd_next;
        q_reg    <= q_next;
        oy_reg   <= oy_next;
        om_reg   <= om_next;
        od_reg   <= od_next;
        owd_reg  <= owd_next;
        oerr_reg <= oerr_next;
    end

    assign m_valid     = mv_reg;
    assign m_out_year  = oy_reg;
    assign m_out_month = om_reg;
    assign m_out_day   = od_reg;
    assign m_weekday   = owd_reg;
    assign m_error     = oerr_reg;

    a_good_date: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !oerr_reg) |->
        (oy_reg >= 14'd1 && oy_reg <= cds_pkg::YEAR_MAX &&
         om_reg >= 4'd1 && om_reg <= 4'd12 && od_reg >= 5'd1 && owd_reg <= 3'd6))
        else $error("error-free result carries an impossible date");

    a_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && oerr_reg && oy_reg != 14'd0) |->
        (oy_reg == cds_pkg::YEAR_MAX && om_reg == 4'd12 && od_reg == 5'd31 &&
         owd_reg == 3'd5))
        else $error("overflowed result is not saturated to the last date");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |=>
        (mv_reg && $stable(oy_reg) && $stable(om_reg) && $stable(od_reg) &&
         $stable(owd_reg) && $stable(oerr_reg)))
        else $error("waiting result beat changed before it was taken");

endmodule

// ----- hw/rtl/calendar_date_stepper.sv -----
// Top level of the calendar date stepper: joins the micro-sequencer and the
// datapath. Depends on cds_pkg, cds_sequencer and cds_datapath.
//
// The block takes one Gregorian date beat with an action and a count, and
// returns one result beat: the date moved on by a number of days, months or
// years, or to the next Sunday or next weekday, with its day of the week
// (0 is Sunday) and an error flag. An invalid input date gives error set and
// every other field zero; a result past 9999-12-31 gives error set and that
// last date, a Friday. Actions 5 to 7 return the input date unchanged. The
// work is done by a short program held in a read-only table, one control word
// per cycle (the last word waits until the output register is free), stepping
// a single shared datapath; one date is in flight at a time, and a new beat
// is taken as soon as the previous result has been moved into the output
// register, so the next date runs while that result waits. Adding days walks
// the day-by-day loop of the program, one pass through three control words
// per day and two more for each new year crossed.
module calendar_date_stepper (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cds_pkg::ACT_W-1:0]   s_action,
    input  logic [cds_pkg::YEAR_W-1:0]  s_year,
    input  logic [cds_pkg::MONTH_W-1:0] s_month,
    input  logic [cds_pkg::DAY_W-1:0]   s_day,
    input  logic [cds_pkg::AMT_W-1:0]   s_amount,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cds_pkg::YEAR_W-1:0]  m_out_year,
    output logic [cds_pkg::MONTH_W-1:0] m_out_month,
    output logic [cds_pkg::DAY_W-1:0]   m_out_day,
    output logic [cds_pkg::WD_W-1:0]    m_weekday,
    output logic                        m_error
);

    // Control word fields that reach the datapath, and the flags the program
    // branches on, travel between the two halves as structs.
    cds_pkg::cds_ctrl_t ctrl;
    cds_pkg::cds_stat_t stat;

    cds_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    cds_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .stat        (stat),
        .s_action    (s_action),
        .s_year      (s_year),
        .s_month     (s_month),
        .s_day       (s_day),
        .s_amount    (s_amount),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_year  (m_out_year),
        .m_out_month (m_out_month),
        .m_out_day   (m_out_day),
        .m_weekday   (m_weekday),
        .m_error     (m_error)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for calendar_date_stepper: a directed list of dates, then random
// dates under several idle and stall patterns, every result beat checked as it arrives.
// Depends on cds_pkg and the calendar_date_stepper RTL; it reads and writes no files.
module tb_top;

    // Action codes that the block does not define. They must hand the date back untouched.
    localparam logic [cds_pkg::ACT_W-1:0] ACT_RESERVED_5 = 3'd5;
    localparam logic [cds_pkg::ACT_W-1:0] ACT_RESERVED_6 = 3'd6;
    localparam logic [cds_pkg::ACT_W-1:0] ACT_RESERVED_7 = 3'd7;

    // Day-of-week codes, Sunday first.
    localparam int unsigned WD_SUNDAY   = 0;
    localparam int unsigned WD_MONDAY   = 1;
    localparam int unsigned WD_FRIDAY   = 5;
    localparam int unsigned WD_SATURDAY = 6;

    localparam int unsigned BEATS_PER_PHASE = 285;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES    = 64;
    localparam int unsigned MAX_REPORTS     = 100;

    // One result beat, at the widths of the output ports.
    typedef struct packed {
        logic [cds_pkg::YEAR_W-1:0]  year;
        logic [cds_pkg::MONTH_W-1:0] month;
        logic [cds_pkg::DAY_W-1:0]   day;
        logic [cds_pkg::WD_W-1:0]    weekday;
        logic                        error;
    } date_result_t;

    // One input beat. Where known is set, the expected result is typed into want and the
    // predictor is not consulted.
    typedef struct packed {
        logic [cds_pkg::ACT_W-1:0]   action;
        logic [cds_pkg::YEAR_W-1:0]  year;
        logic [cds_pkg::MONTH_W-1:0] month;
        logic [cds_pkg::DAY_W-1:0]   day;
        logic [cds_pkg::AMT_W-1:0]   amount;
        logic                        known;
        date_result_t                want;
    } date_req_t;

    // Working date of the predictor, wide enough to hold a year past the last one.
    typedef struct packed {
        logic        past_end;
        int unsigned y;
        int unsigned m;
        int unsigned d;
    } cal_date_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [cds_pkg::YEAR_W-1:0]  m_out_year;
    logic [cds_pkg::MONTH_W-1:0] m_out_month;
    logic [cds_pkg::DAY_W-1:0]   m_out_day;
    logic [cds_pkg::WD_W-1:0]    m_weekday;
    logic                        m_error;

    // The beat on offer. Its fields drive the input ports directly, so every input is known
    // from time zero.
    date_req_t offered = '0;

    date_result_t    pending_dates [$];
    int unsigned     mismatch_count = 0;
    int unsigned     results_seen   = 0;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     hold_left      = 0;
    longint unsigned cycle_count    = 0;
    longint unsigned cycle_limit    = 200000;

    calendar_date_stepper dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (offered.action),
        .s_year      (offered.year),
        .s_month     (offered.month),
        .s_day       (offered.day),
        .s_amount    (offered.amount),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_year  (m_out_year),
        .m_out_month (m_out_month),
        .m_out_day   (m_out_day),
        .m_weekday   (m_weekday),
        .m_error     (m_error)
    );

    // Eight time units per clock period.
    always #4 aclk = ~aclk;

    // ---------------------------------------------------------------------------------------
    // Calendar arithmetic used for prediction.
    // ---------------------------------------------------------------------------------------

    // A year is leap if divisible by 4, except for centuries that are not divisible by 400.
    function automatic logic is_leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        case (m)
            2:            return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    // Counting months from March puts the leap day at the end of the year, so January and
    // February are treated as months 11 and 12 of the year before.
    function automatic int unsigned weekday_of(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        if (m < 3) begin
            y = y - 1;
            m = m + 10;
        end else begin
            m = m - 2;
        end
        return (d + 31 * m / 12 + y + y / 4 - y / 100 + y / 400) % 7;
    endfunction

    // Moves on by one day. Stepping past the last day of year 9999 flags past_end and leaves
    // the rest of the date meaningless; the caller saturates it.
    function automatic cal_date_t next_date(input cal_date_t c);
        if (c.d < month_length(c.y, c.m)) begin
            c.d = c.d + 1;
        end else begin
            c.d = 1;
            if (c.m < 12) begin
                c.m = c.m + 1;
            end else begin
                c.m = 1;
                if (c.y >= 32'(cds_pkg::YEAR_MAX))
                    c.past_end = 1'b1;
                else
                    c.y = c.y + 1;
            end
        end
        return c;
    endfunction

    function automatic date_result_t predict_date(input date_req_t r);
        cal_date_t    c;
        date_result_t res;
        int unsigned  total;
        int unsigned  n;
        int unsigned  wd;
        c.past_end = 1'b0;
        c.y        = 32'(r.year);
        c.m        = 32'(r.month);
        c.d        = 32'(r.day);
        res        = '0;
        // An impossible starting date gives error alone, every other field zero, whatever
        // the action.
        if (c.y < 1 || c.y > 32'(cds_pkg::YEAR_MAX) || c.m < 1 || c.m > 12 ||
            c.d < 1 || c.d > month_length(c.y, c.m)) begin
            res.error = 1'b1;
            return res;
        end
        case (r.action)
            cds_pkg::ACT_ADD_DAYS: begin
                for (n = 0; n < 32'(r.amount) && !c.past_end; n++)
                    c = next_date(c);
            end
            cds_pkg::ACT_ADD_MONTHS: begin
                total = c.m - 1 + 32'(r.amount);
                c.y   = c.y + total / 12;
                c.m   = total % 12 + 1;
                if (c.y > 32'(cds_pkg::YEAR_MAX))
                    c.past_end = 1'b1;
                else if (c.d > month_length(c.y, c.m))
                    c.d = month_length(c.y, c.m);
            end
            cds_pkg::ACT_ADD_YEARS: begin
                c.y = c.y + 32'(r.amount);
                if (c.y > 32'(cds_pkg::YEAR_MAX))
                    c.past_end = 1'b1;
                else if (c.d > month_length(c.y, c.m))
                    c.d = month_length(c.y, c.m);
            end
            cds_pkg::ACT_NEXT_SUNDAY: begin
                do
                    c = next_date(c);
                while (!c.past_end && weekday_of(c.y, c.m, c.d) != WD_SUNDAY);
            end
            cds_pkg::ACT_NEXT_WEEKDAY: begin
                do begin
                    c  = next_date(c);
                    wd = weekday_of(c.y, c.m, c.d);
                end while (!c.past_end && (wd == WD_SUNDAY || wd == WD_SATURDAY));
            end
            default: begin
            end
        endcase
        // Running off the end of the calendar pins the result to its last day.
        if (c.past_end) begin
            c.y = 32'(cds_pkg::YEAR_MAX);
            c.m = 12;
            c.d = 31;
        end
        res.year    = 14'(c.y);
        res.month   = 4'(c.m);
        res.day     = 5'(c.d);
        res.weekday = 3'(weekday_of(c.y, c.m, c.d));
        res.error   = c.past_end;
        return res;
    endfunction

    // ---------------------------------------------------------------------------------------
    // Stimulus.
    // ---------------------------------------------------------------------------------------

    function automatic date_req_t row_predicted(input logic [cds_pkg::ACT_W-1:0] act,
                                                input int unsigned y, m, d, amt);
        date_req_t r;
        r        = '0;
        r.action = act;
        r.year   = 14'(y);
        r.month  = 4'(m);
        r.day    = 5'(d);
        r.amount = 16'(amt);
        return r;
    endfunction

    function automatic date_req_t row_known(input logic [cds_pkg::ACT_W-1:0] act,
                                            input int unsigned y, m, d, amt,
                                            input int unsigned wy, wm, wd, wwd, werr);
        date_req_t r;
        r              = row_predicted(act, y, m, d, amt);
        r.known        = 1'b1;
        r.want.year    = 14'(wy);
        r.want.month   = 4'(wm);
        r.want.day     = 5'(wd);
        r.want.weekday = 3'(wwd);
        r.want.error   = 1'(werr);
        return r;
    endfunction

    // Random dates lean on the interesting corners: the first and last few years of the
    // calendar, years either side of a century, and month ends. About one in ten is broken.
    // Day counts stay mostly small, since the block walks them one day at a time.
    function automatic date_req_t make_random_date();
        date_req_t   r;
        int unsigned pick;
        int unsigned y;
        int unsigned m;
        int unsigned len;
        r    = '0;
        pick = $urandom_range(99);
        if (pick < 30)
            r.action = cds_pkg::ACT_ADD_DAYS;
        else if (pick < 45)
            r.action = cds_pkg::ACT_ADD_MONTHS;
        else if (pick < 60)
            r.action = cds_pkg::ACT_ADD_YEARS;
        else if (pick < 75)
            r.action = cds_pkg::ACT_NEXT_SUNDAY;
        else if (pick < 90)
            r.action = cds_pkg::ACT_NEXT_WEEKDAY;
        else
            r.action = 3'($urandom_range(ACT_RESERVED_7, ACT_RESERVED_5));
        case ($urandom_range(3))
            0:       y = $urandom_range(30, 1);
            1:       y = $urandom_range(9999, 9970);
            2:       y = 100 * $urandom_range(99, 1) + $urandom_range(2) - 1;
            default: y = $urandom_range(9999, 1);
        endcase
        m       = $urandom_range(12, 1);
        len     = month_length(y, m);
        r.year  = 14'(y);
        r.month = 4'(m);
        r.day   = ($urandom_range(9) < 3) ? 5'(len) : 5'($urandom_range(len, 1));
        if ($urandom_range(9) == 0) begin
            if ($urandom_range(1) == 1) begin
                r.year  = 14'($urandom_range((1 << cds_pkg::YEAR_W) - 1));
                r.month = 4'($urandom_range((1 << cds_pkg::MONTH_W) - 1));
                r.day   = 5'($urandom_range((1 << cds_pkg::DAY_W) - 1));
            end else begin
                r.day = (len == 31) ? 5'd0 : 5'($urandom_range(31, len + 1));
            end
        end
        pick = $urandom_range(99);
        case (r.action)
            cds_pkg::ACT_ADD_DAYS: begin
                if (pick < 85)
                    r.amount = 16'($urandom_range(60));
                else if (pick < 97)
                    r.amount = 16'($urandom_range(1500));
                else
                    r.amount = 16'($urandom_range(3000));
            end
            cds_pkg::ACT_ADD_MONTHS, cds_pkg::ACT_ADD_YEARS: begin
                if (pick < 50)
                    r.amount = 16'($urandom_range(40));
                else
                    r.amount = 16'($urandom_range((1 << cds_pkg::AMT_W) - 1));
            end
            default: begin
                r.amount = 16'($urandom_range((1 << cds_pkg::AMT_W) - 1));
            end
        endcase
        return r;
    endfunction

    // Offers one beat and returns at the falling edge after it has been taken. Valid is left
    // high, so a beat offered straight away follows without a bubble. The watchdog limit is
    // raised by a generous multiple of the worst case for this beat, which for added days
    // grows with the number of days and of years crossed.
    task automatic offer_date(input date_req_t r);
        longint unsigned span;
        span = 100;
        if (r.action == cds_pkg::ACT_ADD_DAYS)
            span = span + 3 * r.amount + 2 * (r.amount / 365) + 20;
        cycle_limit = cycle_limit + 4 * span;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        offered <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] result beat %0d: %s is %0d, expected %0d",
                     $time, results_seen, what, got, want);
    endtask

    // ---------------------------------------------------------------------------------------
    // Receiver. Ready changes at the falling edge. A hold-off request keeps it low for a
    // counted number of cycles, so that the block fills up and has to refuse input beats.
    // ---------------------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------------------------------
    // Scoreboard. Both handshakes are sampled at the rising edge. An accepted input beat
    // queues its expected result; an accepted result beat is compared field by field with
    // the oldest one waiting.
    // ---------------------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        date_result_t got;
        date_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (offered.known)
                    pending_dates.push_back(offered.want);
                else
                    pending_dates.push_back(predict_date(offered));
            end
            if (m_valid && m_ready) begin
                results_seen++;
                got.year    = m_out_year;
                got.month   = m_out_month;
                got.day     = m_out_day;
                got.weekday = m_weekday;
                got.error   = m_error;
                if (pending_dates.size() == 0) begin
                    report_mismatch("count of result beats with no date waiting", 1, 0);
                end else begin
                    want = pending_dates.pop_front();
                    if (got.year != want.year)
                        report_mismatch("year", 32'(got.year), 32'(want.year));
                    if (got.month != want.month)
                        report_mismatch("month", 32'(got.month), 32'(want.month));
                    if (got.day != want.day)
                        report_mismatch("day", 32'(got.day), 32'(want.day));
                    if (got.weekday != want.weekday)
                        report_mismatch("weekday", 32'(got.weekday), 32'(want.weekday));
                    if (got.error != want.error)
                        report_mismatch("error", 32'(got.error), 32'(want.error));
                end
            end
        end
    end

    // Watchdog. The limit grows with each beat offered, so a long run is not cut short,
    // but a block that hangs or loses a result is.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Test sequence.
    // ---------------------------------------------------------------------------------------
    initial begin : test_sequence
        date_req_t   rows [$];
        int unsigned i;
        int unsigned p;

        // Synchronous reset, held low and then released at a falling edge.
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed dates. Results that are plain from the rules (impossible dates, the end
        // of the calendar, the very first day) are written in; the rest are predicted.
        // The first day of year 1 is a Monday, and 31 December 9999 is a Friday.
        rows.push_back(row_known(cds_pkg::ACT_ADD_DAYS, 1, 1, 1, 0, 1, 1, 1, WD_MONDAY, 0));
        rows.push_back(row_known(cds_pkg::ACT_ADD_DAYS, 9999, 12, 31, 0,
                                 9999, 12, 31, WD_FRIDAY, 0));
        rows.push_back(row_known(cds_pkg::ACT_ADD_DAYS, 9999, 12, 31, 1,
                                 9999, 12, 31, WD_FRIDAY, 1));
        rows.push_back(row_predicted(cds_pkg::ACT_ADD_DAYS, 2024, 2, 28, 1));
        rows.push_back(row_predicted(cds_pkg::ACT_ADD_DAYS, 2000, 2, 29, 1));
        // Impossible dates: year zero, year past the end, every date bit set, month zero,
        // month thirteen, day zero, and a leap day in a century that is not a leap year.
        rows.push_back(row_known(cds_pkg::ACT_ADD_DAYS, 0, 1, 1, 5, 0, 0, 0, 0, 1));
        rows.push_back(row_known(cds_pkg::ACT_ADD_MONTHS, 10000, 6, 15, 1, 0, 0, 0, 0, 1));
        rows.push_back(row_known(cds_pkg::ACT_ADD_YEARS, 16383, 15, 31, 65535,
                                 0, 0, 0, 0, 1));
        rows.push_back(row_known(cds_pkg::ACT_NEXT_SUNDAY, 2020, 0, 10, 0, 0, 0, 0, 0, 1));
        rows.push_back(row_known(cds_pkg::ACT_NEXT_WEEKDAY, 2020, 13, 10, 0, 0, 0, 0, 0, 1));
        rows.push_back(row_known(cds_pkg::ACT_ADD_DAYS, 2020, 5, 0, 3, 0, 0, 0, 0, 1));
        rows.push_back(row_known(cds_pkg::ACT_ADD_DAYS, 1900, 2, 29, 1, 0, 0, 0, 0, 1));
        // Month and year steps: the largest count, clamping to a shorter month, and
        // running past the last year.
        rows.push_back(row_predicted(cds_pkg::ACT_ADD_MONTHS, 2000, 1, 31, 65535));
        rows.push_back(row_known(cds_pkg::ACT_ADD_MONTHS, 9999, 6, 15, 7,
                                 9999, 12, 31, WD_FRIDAY, 1));
        rows.push_back(row_predicted(cds_pkg::ACT_ADD_YEARS, 2000, 2, 29, 1));
        rows.push_back(row_known(cds_pkg::ACT_ADD_YEARS, 1, 1, 1, 65535,
                                 9999, 12, 31, WD_FRIDAY, 1));
        // Seeking: the count is ignored, and a search that runs off the calendar saturates.
        rows.push_back(row_predicted(cds_pkg::ACT_NEXT_SUNDAY, 9999, 12, 25, 65535));
        rows.push_back(row_known(cds_pkg::ACT_NEXT_SUNDAY, 9999, 12, 27, 0,
                                 9999, 12, 31, WD_FRIDAY, 1));
        rows.push_back(row_known(cds_pkg::ACT_NEXT_WEEKDAY, 9999, 12, 31, 0,
                                 9999, 12, 31, WD_FRIDAY, 1));
        rows.push_back(row_predicted(cds_pkg::ACT_NEXT_WEEKDAY, 2024, 5, 31, 0));
        // Undefined actions pass a good date through; a bad date still reports an error.
        rows.push_back(row_predicted(ACT_RESERVED_5, 2024, 7, 4, 1234));
        rows.push_back(row_predicted(ACT_RESERVED_6, 1, 1, 1, 0));
        rows.push_back(row_predicted(ACT_RESERVED_7, 9999, 12, 31, 65535));
        rows.push_back(row_known(ACT_RESERVED_7, 2019, 2, 29, 0, 0, 0, 0, 0, 1));
        // The largest day count, once in range and once running off the end.
        rows.push_back(row_predicted(cds_pkg::ACT_ADD_DAYS, 2000, 1, 1, 65535));
        rows.push_back(row_known(cds_pkg::ACT_ADD_DAYS, 9900, 1, 1, 65535,
                                 9999, 12, 31, WD_FRIDAY, 1));

        for (i = 0; i < rows.size(); i++)
            offer_date(rows[i]);

        // Random dates in four phases: no idling at all, then an idle sender, then a
        // stalling receiver, then light idling on both sides. The first phase opens with a
        // long receiver hold-off while the sender keeps offering.
        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_left      = HOLD_OFF_CYCLES;
                    cycle_limit    = cycle_limit + 4 * HOLD_OFF_CYCLES;
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            for (i = 0; i < BEATS_PER_PHASE; i++)
                offer_date(make_random_date());
        end

        // Stop offering and let every outstanding result drain, then wait a little longer
        // for anything the block should not send.
        s_valid        <= 1'b0;
        recv_stall_pct = 0;
        while (pending_dates.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
